// ----- hdl/bbus_pkg.sv -----
// Shared types, constants and the reciprocal table of the unsharp sharpener.
package bbus_pkg;

   localparam int PIX_W       = 8;
   localparam int RGB_W       = 3 * PIX_W;
   localparam int SUM_W       = 12;
   localparam int CNT_W       = 4;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;
   localparam int FW_W        = 12;
   localparam int FH_W        = 16;
   localparam int POS_W       = 17;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int TAPS        = 9;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0]  FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [PIX_W-1:0] PIX_MAX            = 8'd255;
   localparam logic [FH_W-1:0]  ROW_MAX            = 16'hFFFF;

   typedef logic [RGB_W-1:0] rgb_type;

   // tap index is column * 3 + row; column 0 oldest, row 0 top
   typedef logic [TAPS-1:0][RGB_W-1:0] window_type;
   typedef logic [TAPS-1:0][PIX_W-1:0] chan_window_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             drain;
   } pixel_in_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             frame_end;
   } pixel_out_type;

   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
   } edge_mask_type;

   typedef struct packed {
      logic load_sum;
      logic load_avg;
   } lane_ctrl_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } line_ctrl_type;

   // ceil(2^16 / count): exact quotient for sums below 2^12
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/bbus_chan_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
interface bbus_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/bbus_window.sv -----
// Two line buffers and the 3x3 pixel window they feed.
module bbus_window
   import bbus_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int AW        = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  line_ctrl_type ctrl,
   input  logic [AW-1:0] rd_col,
   input  logic [AW-1:0] wr_col,
   input  rgb_type       pix,
   output window_type    window
);

   rgb_type    upper_mem [MAX_WIDTH];
   rgb_type    middle_mem [MAX_WIDTH];
   rgb_type    top_rd_ff;
   rgb_type    mid_rd_ff;
   window_type window_ff;

   // read both lines on accept, write them back in the next cycle
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         top_rd_ff <= upper_mem[rd_col];
         mid_rd_ff <= middle_mem[rd_col];
      end
      if (ctrl.commit) begin
         upper_mem[wr_col]  <= mid_rd_ff;
         middle_mem[wr_col] <= pix;
      end
   end

   // shift the window left by one column and load the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (ctrl.commit) begin
         window_ff <= {pix, mid_rd_ff, top_rd_ff, window_ff[TAPS-1:3]};
      end
   end

   assign window = window_ff;

endmodule

// ----- hdl/bbus_lane.sv -----
// One colour lane: masked box sum, division by the tap count, sharpening.
module bbus_lane
   import bbus_pkg::*;
(
   input  logic             clock,
   input  lane_ctrl_type    ctrl,
   input  edge_mask_type    mask,
   input  chan_window_type  chan,
   output logic [PIX_W-1:0] result
);

   logic [SUM_W-1:0]         sum_in;
   logic [SUM_W-1:0]         sum_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         count_ff;
   logic [SUM_W+RECIP_W-1:0] product;
   logic [PIX_W-1:0]         avg_in;
   logic [PIX_W-1:0]         avg_ff;
   logic [PIX_W-1:0]         orig;
   logic [PIX_W-1:0]         detail;
   logic [PIX_W:0]           total;

   // add the taps that lie inside the frame
   always_comb begin
      logic take;
      sum_in   = '0;
      count_in = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            take = !((c == 0 && !mask.left) || (c == 2 && !mask.right) ||
                     (r == 0 && !mask.top)  || (r == 2 && !mask.bottom));
            if (take) begin
               sum_in   = sum_in + SUM_W'(chan[c*3+r]);
               count_in = count_in + CNT_W'(1);
            end
         end
      end
   end

   // divide by multiplying with the reciprocal
   assign product = SUM_W'(sum_ff) * recip(count_ff);
   assign avg_in  = product[RECIP_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
      if (ctrl.load_avg) begin
         avg_ff <= avg_in;
      end
   end

   // floor the detail at zero, saturate the sum
   assign orig   = chan[4];
   assign detail = (orig > avg_ff) ? (orig - avg_ff) : '0;
   assign total  = {1'b0, orig} + {1'b0, detail};
   assign result = total[PIX_W] ? PIX_MAX : total[PIX_W-1:0];

endmodule

// ----- hdl/box_blur_unsharp_sharpener.sv -----
// Top level of the 3x3 box blur unsharp sharpener.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    red, green, blue, drain
//   rsp_chan  out        valid / ready    out_red, out_green, out_blue, frame_end
//   csr_*     in         csr_write only   csr_index, csr_wdata
//
// An item that yields no result passes the line read and the window load; one that yields
// a result also passes the lane sum, the reciprocal multiply and the output load, and waits
// while the output register is still full. Reset is synchronous, restores the default
// configuration and clears positions and the window; the line buffers are not cleared.
// A stalled result waits in the output register.
module box_blur_unsharp_sharpener
   import bbus_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   bbus_chan_if.sink             req_chan,
   bbus_chan_if.source           rsp_chan,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic [AW-1:0]   in_column_ff, in_column_in;
   logic [FH_W-1:0] in_row_ff, in_row_in;
   logic [AW-1:0]   out_column_ff, out_column_in;
   logic [FH_W-1:0] out_row_ff, out_row_in;
   logic            out_valid_ff, out_valid_in;
   pixel_out_type   out_ff, out_in;

   logic [AW-1:0]   col_ff;
   rgb_type         pix_ff;
   edge_mask_type   mask_ff;
   logic            fend_ff;
   logic            due_ff;

   logic [POS_W-1:0] eff_width;
   logic [POS_W-1:0] eff_height;
   logic             in_last_col;
   logic             out_last_col;
   logic             out_last_row;
   logic             due;
   logic             req_fire;
   logic             out_load;

   line_ctrl_type       line_ctrl;
   lane_ctrl_type       lane_ctrl;
   window_type          window;
   logic [2:0][PIX_W-1:0] lane_res;

   // effective frame size: zero acts as one, width capped at the buffer depth
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = POS_W'(1);
      end else if (POS_W'(frame_width_ff) > POS_W'(MAX_WIDTH)) begin
         eff_width = POS_W'(MAX_WIDTH);
      end else begin
         eff_width = POS_W'(frame_width_ff);
      end
      eff_height = (frame_height_ff == '0) ? POS_W'(1) : POS_W'(frame_height_ff);
   end

   assign in_last_col  = (POS_W'(in_column_ff) + POS_W'(1)) >= eff_width;
   assign out_last_col = (POS_W'(out_column_ff) + POS_W'(1)) >= eff_width;
   assign out_last_row = (POS_W'(out_row_ff) + POS_W'(1)) >= eff_height;
   assign due          = (in_row_ff >= FH_W'(2)) ||
                         (in_row_ff == FH_W'(1) && in_column_ff != '0);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_load       = (state_ff == ST_OUT) && (!out_valid_ff || rsp_chan.ready);

   // sequencer and position counters
   always_comb begin
      state_in      = state_ff;
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOAD;
               if (in_last_col) begin
                  in_column_in = '0;
                  if (in_row_ff != ROW_MAX) in_row_in = in_row_ff + FH_W'(1);
               end else begin
                  in_column_in = in_column_ff + AW'(1);
               end
               if (due) begin
                  if (out_last_col && out_last_row) begin
                     in_column_in  = '0;
                     in_row_in     = '0;
                     out_column_in = '0;
                     out_row_in    = '0;
                  end else if (out_last_col) begin
                     out_column_in = '0;
                     out_row_in    = out_row_ff + FH_W'(1);
                  end else begin
                     out_column_in = out_column_ff + AW'(1);
                  end
               end
            end
         end
         ST_LOAD: state_in = due_ff ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // merge the lane results into one output beat
   always_comb begin
      out_in.out_red   = lane_res[0];
      out_in.out_green = lane_res[1];
      out_in.out_blue  = lane_res[2];
      out_in.frame_end = fend_ff;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         in_column_ff    <= '0;
         in_row_ff       <= '0;
         out_column_ff   <= '0;
         out_row_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         out_valid_ff  <= out_valid_in;
         if (csr_write && csr_index == REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[FW_W-1:0];
         end
         if (csr_write && csr_index == REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata[FH_W-1:0];
         end
      end
   end

   // hold the accepted beat and its edge flags, and load the output register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_ff         <= req_chan.payload.drain ? '0 :
                           {req_chan.payload.red, req_chan.payload.green,
                            req_chan.payload.blue};
         col_ff         <= in_column_ff;
         due_ff         <= due;
         fend_ff        <= out_last_col && out_last_row;
         mask_ff.left   <= out_column_ff != '0;
         mask_ff.right  <= !out_last_col;
         mask_ff.top    <= out_row_ff != '0;
         mask_ff.bottom <= !out_last_row;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign line_ctrl.capture = req_fire;
   assign line_ctrl.commit  = (state_ff == ST_LOAD);
   assign lane_ctrl.load_sum = (state_ff == ST_SUM);
   assign lane_ctrl.load_avg = (state_ff == ST_DIV);

   bbus_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (line_ctrl),
      .rd_col (in_column_ff),
      .wr_col (col_ff),
      .pix    (pix_ff),
      .window (window)
   );

   // one lane per colour, red in the top byte
   for (genvar l = 0; l < 3; l++) begin : g_lane
      chan_window_type chan;
      for (genvar i = 0; i < TAPS; i++) begin : g_tap
         assign chan[i] = window[i][(2-l)*PIX_W +: PIX_W];
      end
      bbus_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .mask   (mask_ff),
         .chan   (chan),
         .result (lane_res[l])
      );
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

// ----- hdl/bbus_checker.sv -----
// Port-level checks of the sharpener, bound to the top level.
module bbus_checker
   import bbus_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input pixel_out_type rsp_payload
);

   // a stalled result beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // one beat at a time: ready drops after an accept
   a_one_beat: assert property (@(posedge clock)
      !reset && req_valid && req_ready |=> !req_ready)
      else $error("input accepted on two consecutive cycles");

   // a new result is loaded only while the input side is closed
   a_rsp_rise: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while input was open");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind box_blur_unsharp_sharpener bbus_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
